// ----- rtl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared sizes, the candidate record that travels down the cell row, the
// command record broadcast to every cell, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 16;
  localparam int SLOT_BITS = 4;
  localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic [TIME_BITS-1:0] tval_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // Best slot seen so far on its way down the row.
  typedef struct packed {
    logic  found;
    tval_t rem;
    idx_t  idx;
    tval_t arr;
    tval_t bur;
  } cand_t;

  // Broadcast from the controller to all cells.
  typedef struct packed {
    logic                 load;
    logic [SLOT_BITS-1:0] load_slot;
    tval_t                arr;
    tval_t                bur;
    logic                 dec;
    idx_t                 dec_idx;
    tval_t                now;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/srtf_cell.sv -----
// ----------------------------------------------------------------------------
// SRTF slot cell
// Holds one process slot and passes the running best candidate to the next
// cell, replacing it when this slot is eligible and strictly shorter.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire srtf_pkg::idx_t cell_idx,
  input  wire srtf_pkg::cmd_t cmd,
  input  wire srtf_pkg::cand_t cand_in,
  output srtf_pkg::cand_t     cand_out
);

  srtf_pkg::tval_t arr_r, arr_nxt;
  srtf_pkg::tval_t bur_r, bur_nxt;
  srtf_pkg::tval_t rem_r, rem_nxt;
  srtf_pkg::cand_t cand_r, cand_nxt;

  logic load_hit;
  logic dec_hit;
  logic eligible;
  logic take;

  always_comb begin
    load_hit = cmd.load && (32'(cmd.load_slot) == 32'(cell_idx));
    dec_hit  = cmd.dec && (cmd.dec_idx == cell_idx);

    arr_nxt = arr_r;
    bur_nxt = bur_r;
    rem_nxt = rem_r;
    if (load_hit) begin
      arr_nxt = cmd.arr;
      bur_nxt = cmd.bur;
      rem_nxt = cmd.bur;
    end else if (dec_hit) begin
      rem_nxt = rem_r - 1'b1;
    end

    // Ties keep the incoming candidate, so the lowest slot wins.
    eligible = (rem_r != '0) && (arr_r <= cmd.now);
    take     = eligible && (!cand_in.found || (rem_r < cand_in.rem));
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.rem   = rem_r;
      cand_nxt.idx   = cell_idx;
      cand_nxt.arr   = arr_r;
      cand_nxt.bur   = bur_r;
    end else begin
      cand_nxt = cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      cand_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arr_r <= arr_nxt;
    bur_r <= bur_nxt;
  end

  assign cand_out = cand_r;

endmodule

`default_nettype wire

// ----- rtl/srtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// SRTF controller
// Takes input beats, times the scan down the cell row, keeps the clock of
// the scheduler and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [srtf_pkg::SLOT_BITS-1:0] in_slot,
  input  wire srtf_pkg::tval_t                in_arrival,
  input  wire srtf_pkg::tval_t                in_burst,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_ran_valid,
  output logic [srtf_pkg::SLOT_BITS-1:0]      out_ran_slot,
  output logic                                out_done_res,
  output srtf_pkg::tval_t                     out_finish_time,
  output srtf_pkg::tval_t                     out_turnaround_time,
  output srtf_pkg::tval_t                     out_waiting_time,
  output srtf_pkg::tval_t                     out_now,
  output srtf_pkg::cmd_t                      cmd,
  input  wire srtf_pkg::cand_t                best
);

  srtf_pkg::state_t state_r, state_nxt;
  srtf_pkg::idx_t   cnt_r, cnt_nxt;
  srtf_pkg::tval_t  now_r, now_nxt;

  logic                           vld_r, vld_nxt;
  logic                           ran_r, ran_nxt;
  logic [srtf_pkg::SLOT_BITS-1:0] slot_r, slot_nxt;
  logic                           done_r, done_nxt;
  srtf_pkg::tval_t                fin_r, fin_nxt;
  srtf_pkg::tval_t                tat_r, tat_nxt;
  srtf_pkg::tval_t                wt_r, wt_nxt;
  srtf_pkg::tval_t                nowo_r, nowo_nxt;

  logic            in_acc;
  logic            fire;
  logic            done;
  srtf_pkg::tval_t now_sat;
  srtf_pkg::tval_t tat;
  srtf_pkg::tval_t wt;

  always_comb begin
    in_stall = (state_r != srtf_pkg::ST_IDLE);
    in_acc   = in_valid && !in_stall;

    cmd.load      = in_acc && (in_action == srtf_pkg::ACT_LOAD);
    cmd.load_slot = in_slot;
    cmd.arr       = in_arrival;
    cmd.bur       = in_burst;
    cmd.dec       = 1'b0;
    cmd.dec_idx   = best.idx;
    cmd.now       = now_r;

    now_sat = (now_r == '1) ? now_r : now_r + 1'b1;
    done    = best.found && (best.rem == srtf_pkg::tval_t'(1));
    tat     = (now_sat >= best.arr) ? now_sat - best.arr : '0;
    wt      = (tat >= best.bur) ? tat - best.bur : '0;

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    now_nxt   = now_r;
    fire      = 1'b0;

    case (state_r)
      srtf_pkg::ST_IDLE: begin
        if (in_acc && (in_action == srtf_pkg::ACT_TICK)) begin
          state_nxt = srtf_pkg::ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      srtf_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == srtf_pkg::idx_t'(srtf_pkg::SLOTS - 1)) begin
          state_nxt = srtf_pkg::ST_UPDATE;
        end
      end
      srtf_pkg::ST_UPDATE: begin
        if (!vld_r || !out_stall) begin
          fire      = 1'b1;
          cmd.dec   = best.found;
          now_nxt   = now_sat;
          state_nxt = srtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase

    vld_nxt  = vld_r;
    ran_nxt  = ran_r;
    slot_nxt = slot_r;
    done_nxt = done_r;
    fin_nxt  = fin_r;
    tat_nxt  = tat_r;
    wt_nxt   = wt_r;
    nowo_nxt = nowo_r;
    if (fire) begin
      vld_nxt  = 1'b1;
      ran_nxt  = best.found;
      slot_nxt = best.found ? srtf_pkg::SLOT_BITS'(best.idx) : '0;
      done_nxt = done;
      fin_nxt  = done ? now_sat : '0;
      tat_nxt  = done ? tat : '0;
      wt_nxt   = done ? wt : '0;
      nowo_nxt = now_sat;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srtf_pkg::ST_IDLE;
      cnt_r   <= '0;
      now_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ran_r  <= ran_nxt;
    slot_r <= slot_nxt;
    done_r <= done_nxt;
    fin_r  <= fin_nxt;
    tat_r  <= tat_nxt;
    wt_r   <= wt_nxt;
    nowo_r <= nowo_nxt;
  end

  assign out_valid           = vld_r;
  assign out_ran_valid       = ran_r;
  assign out_ran_slot        = slot_r;
  assign out_done_res        = done_r;
  assign out_finish_time     = fin_r;
  assign out_turnaround_time = tat_r;
  assign out_waiting_time    = wt_r;
  assign out_now             = nowo_r;

endmodule

`default_nettype wire

// ----- rtl/srtf_tick_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// Shortest-remaining-time-first tick scheduler
// Preemptive SRTF over a row of process slot cells with a scan controller.
// ----------------------------------------------------------------------------
// Usage: an input beat with action load writes one slot's arrival time and
// burst and arms its remaining time; it gives no result.
// A load to a slot beyond the row is ignored. An input beat with action tick
// runs one scheduler tick and gives exactly one result beat.
// A tick stalls the input from its own beat to the next accepted beat: the best
// candidate walks down the row of cells, one cell per cycle, and then the update
// step picks, decrements and registers the result, which sets the result beat
// valid. The next beat is taken in the cycle after that.
// Loads are taken every cycle while no tick is in flight.
// The result sits in an output register, so the next beat is accepted while
// an earlier result still waits; a tick only holds in its final step while
// the previous result is stalled. Reset clears all remaining times, the
// scheduler time and the result valid; the slot contents are left as they
// are, since a slot with no remaining time is never picked.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_tick_scheduler_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [srtf_pkg::SLOT_BITS-1:0] in_slot,
  input  wire srtf_pkg::tval_t                in_arrival,
  input  wire srtf_pkg::tval_t                in_burst,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_ran_valid,
  output logic [srtf_pkg::SLOT_BITS-1:0]      out_ran_slot,
  output logic                                out_done_res,
  output srtf_pkg::tval_t                     out_finish_time,
  output srtf_pkg::tval_t                     out_turnaround_time,
  output srtf_pkg::tval_t                     out_waiting_time,
  output srtf_pkg::tval_t                     out_now
);

  // The command is broadcast to every cell; the candidate chain starts empty
  // at the first cell and the last cell's output is the tick's winner.
  srtf_pkg::cmd_t  cmd;
  srtf_pkg::cand_t chain [srtf_pkg::SLOTS+1];

  assign chain[0] = '0;

  for (genvar g = 0; g < srtf_pkg::SLOTS; g++) begin : g_cell
    srtf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (srtf_pkg::idx_t'(g)),
      .cmd      (cmd),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  srtf_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_slot             (in_slot),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ran_valid       (out_ran_valid),
    .out_ran_slot        (out_ran_slot),
    .out_done_res        (out_done_res),
    .out_finish_time     (out_finish_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_now             (out_now),
    .cmd                 (cmd),
    .best                (chain[srtf_pkg::SLOTS])
  );

endmodule

`default_nettype wire

// ----- tb/srtf_tick_scheduler_top_test.sv -----
// ----------------------------------------------------------------------------
// SRTF tick scheduler testbench
// Drives load and tick beats into the scheduler and predicts every tick result
// with a cycle-free scheduler of its own. Results are checked in order, field
// by field. Both channels idle at random, and a long receiver hold-off fills
// the block so that it has to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_tick_scheduler_top_test;

  // Run limit in clock cycles. It leaves a wide margin over what a correct run
  // needs, even with every receiver stall.
  localparam int LIMIT_CYCLES = 200_000;
  // Extra cycles to wait once nothing is expected any more.
  localparam int DRAIN_CYCLES = srtf_pkg::SLOTS + 8;
  // Number of random beats after the directed part.
  localparam int RANDOM_BEATS = 850;
  // Length of each receiver hold-off, in cycles, and spacing between them, in results.
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_SPACING = 350;
  localparam int TIME_TOP     = (1 << srtf_pkg::TIME_BITS) - 1;

  // One input beat, as it goes onto the input ports.
  typedef struct packed {
    logic                           action;
    logic [srtf_pkg::SLOT_BITS-1:0] slot;
    srtf_pkg::tval_t                arrival;
    srtf_pkg::tval_t                burst;
  } sched_beat_t;

  // One result beat, as it comes off the output ports.
  typedef struct packed {
    logic                           ran_valid;
    logic [srtf_pkg::SLOT_BITS-1:0] ran_slot;
    logic                           done_res;
    srtf_pkg::tval_t                finish_time;
    srtf_pkg::tval_t                turnaround_time;
    srtf_pkg::tval_t                waiting_time;
    srtf_pkg::tval_t                now;
  } tick_result_t;

  // Receiver stall styles, picked at random for stretches of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  // Clock and reset. Every block input starts at a known value.
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_action  = srtf_pkg::ACT_LOAD;
  logic [srtf_pkg::SLOT_BITS-1:0] in_slot    = '0;
  srtf_pkg::tval_t                in_arrival = '0;
  srtf_pkg::tval_t                in_burst   = '0;
  logic                           out_stall  = 1'b0;

  wire                            in_stall;
  wire                            out_valid;
  wire                            out_ran_valid;
  wire [srtf_pkg::SLOT_BITS-1:0]  out_ran_slot;
  wire                            out_done_res;
  srtf_pkg::tval_t                out_finish_time;
  srtf_pkg::tval_t                out_turnaround_time;
  srtf_pkg::tval_t                out_waiting_time;
  srtf_pkg::tval_t                out_now;

  // Beats waiting to be driven, and tick results waiting to come out.
  sched_beat_t  pending_beats [$];
  tick_result_t tick_results_q [$];

  // Our own copy of the scheduler state. Arrival and burst are only read for
  // slots that have been loaded, but they start at zero to keep X out.
  srtf_pkg::tval_t slot_arrival [srtf_pkg::SLOTS] = '{default: '0};
  srtf_pkg::tval_t slot_burst   [srtf_pkg::SLOTS] = '{default: '0};
  srtf_pkg::tval_t slot_left    [srtf_pkg::SLOTS] = '{default: '0};
  srtf_pkg::tval_t sched_now                      = '0;

  // Scheduler time as seen by the stimulus generator: the number of ticks
  // queued so far, saturating like the block does.
  int gen_time = 0;

  int  errors       = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;

  // Driver pacing.
  logic in_took    = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;

  // Receiver pacing. The hold-off counter belongs to the receiver process.
  stall_style_t stall_style  = STALL_NONE;
  int           style_left   = 0;
  int           hold_left    = 0;
  int           next_hold_at = 150;

  srtf_tick_scheduler_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_slot             (in_slot),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ran_valid       (out_ran_valid),
    .out_ran_slot        (out_ran_slot),
    .out_done_res        (out_done_res),
    .out_finish_time     (out_finish_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_now             (out_now)
  );

  always #1 clk = ~clk;

  // Applies one accepted beat to our scheduler copy. A load arms a slot; a
  // tick picks the armed, arrived slot with the least remaining time (lowest
  // slot on a tie), runs it for one tick and queues the expected result.
  task automatic advance_schedule(input sched_beat_t b);
    tick_result_t r;
    logic         found;
    int           pick;
    int           i;
    if (b.action == srtf_pkg::ACT_LOAD) begin
      // Slot numbers beyond the row are dropped by the block.
      if (int'(b.slot) < srtf_pkg::SLOTS) begin
        slot_arrival[b.slot] = b.arrival;
        slot_burst[b.slot]   = b.burst;
        slot_left[b.slot]    = b.burst;
      end
      return;
    end
    found = 1'b0;
    pick  = 0;
    for (i = 0; i < srtf_pkg::SLOTS; i++) begin
      if (slot_arrival[i] <= sched_now && slot_left[i] != '0) begin
        if (!found || slot_left[i] < slot_left[pick]) begin
          found = 1'b1;
          pick  = i;
        end
      end
    end
    // Time stops at its top value.
    if (sched_now != '1) sched_now = sched_now + 1'b1;
    r     = '0;
    r.now = sched_now;
    if (found) begin
      r.ran_valid     = 1'b1;
      r.ran_slot      = srtf_pkg::SLOT_BITS'(pick);
      slot_left[pick] = slot_left[pick] - 1'b1;
      if (slot_left[pick] == '0) begin
        r.done_res        = 1'b1;
        r.finish_time     = sched_now;
        r.turnaround_time = (sched_now >= slot_arrival[pick]) ?
                            sched_now - slot_arrival[pick] : '0;
        // Once time has saturated the turnaround can fall short of the
        // burst; the waiting time then clamps at zero.
        r.waiting_time    = (r.turnaround_time >= slot_burst[pick]) ?
                            r.turnaround_time - slot_burst[pick] : '0;
      end
    end
    tick_results_q.push_back(r);
  endtask

  // Queues one beat and keeps the generator's idea of time in step.
  task automatic queue_beat(input logic act, input int slot, input int arr, input int bur);
    sched_beat_t b;
    b.action  = act;
    b.slot    = srtf_pkg::SLOT_BITS'(slot);
    b.arrival = srtf_pkg::tval_t'(arr);
    b.burst   = srtf_pkg::tval_t'(bur);
    pending_beats.push_back(b);
    if (act == srtf_pkg::ACT_TICK && gen_time < TIME_TOP) gen_time++;
  endtask

  task automatic queue_ticks(input int count);
    repeat (count)
      queue_beat(srtf_pkg::ACT_TICK, $urandom_range(0, srtf_pkg::SLOTS - 1),
                 $urandom, $urandom);
  endtask

  // A random load. Most arrivals sit close to the current time and most
  // bursts are short, so slots compete, preempt each other and finish often.
  // The rest use the full field range, which also toggles every bit.
  task automatic queue_random_load();
    int pick;
    int arr;
    int bur;
    pick = $urandom_range(0, 99);
    if (pick < 65)      arr = gen_time + $urandom_range(0, 6);
    else if (pick < 80) arr = (gen_time > 20) ? gen_time - $urandom_range(0, 20) : 0;
    else                arr = $urandom_range(0, TIME_TOP);
    pick = $urandom_range(0, 99);
    if (pick < 60)      bur = $urandom_range(1, 6);
    else if (pick < 70) bur = 0;
    else if (pick < 85) bur = $urandom_range(7, 40);
    else                bur = $urandom_range(0, TIME_TOP);
    queue_beat(srtf_pkg::ACT_LOAD, $urandom_range(0, srtf_pkg::SLOTS - 1), arr, bur);
  endtask

  // Waits until every queued beat has gone in and every result has come out.
  task automatic wait_for_drain();
    while (pending_beats.size() != 0 || in_valid || tick_results_q.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("srtf_tick_scheduler_top_test failed");
      $finish;
    end
  end

  // Input driver. A beat that was offered and not taken stays on the ports
  // unchanged. Otherwise the next queued beat goes out, in bursts of random
  // length separated by random gaps. Gaps are skipped while the receiver
  // holds off, so the block fills up and has to stall its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // Still waiting for the current beat to be taken.
    end else if (gap_left > 0 && hold_left == 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_beats.size() != 0) begin
      in_valid   <= 1'b1;
      in_action  <= pending_beats[0].action;
      in_slot    <= pending_beats[0].slot;
      in_arrival <= pending_beats[0].arrival;
      in_burst   <= pending_beats[0].burst;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        // About one burst in four runs straight into the next one.
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern. The style changes after random stretches. After
  // every few hundred results the receiver holds off for a long stretch.
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      style_left  <= $urandom_range(20, 120);
    end else begin
      style_left <= style_left - 1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Monitor. An accepted input beat updates our scheduler copy right away,
  // using the values on the ports. An accepted result beat is checked
  // against the oldest expected result.
  always @(posedge clk) begin : monitor
    sched_beat_t  b;
    tick_result_t want;
    tick_result_t got;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      b = {in_action, in_slot, in_arrival, in_burst};
      advance_schedule(b);
      void'(pending_beats.pop_front());
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      got = {out_ran_valid, out_ran_slot, out_done_res, out_finish_time,
             out_turnaround_time, out_waiting_time, out_now};
      if (tick_results_q.size() == 0) begin
        if (errors < 10)
          $display("result beat %0d arrived with no tick pending", results_seen);
        errors = errors + 1;
      end else begin
        want = tick_results_q.pop_front();
        if (got.ran_valid !== want.ran_valid || got.ran_slot !== want.ran_slot ||
            got.done_res !== want.done_res || got.finish_time !== want.finish_time ||
            got.turnaround_time !== want.turnaround_time ||
            got.waiting_time !== want.waiting_time || got.now !== want.now) begin
          if (errors < 10) begin
            $display("result beat %0d mismatch", results_seen);
            $display("  expected ran=%0d slot=%0d done=%0d fin=%0d tat=%0d wait=%0d now=%0d",
                     want.ran_valid, want.ran_slot, want.done_res, want.finish_time,
                     want.turnaround_time, want.waiting_time, want.now);
            $display("  actual   ran=%0d slot=%0d done=%0d fin=%0d tat=%0d wait=%0d now=%0d",
                     got.ran_valid, got.ran_slot, got.done_res, got.finish_time,
                     got.turnaround_time, got.waiting_time, got.now);
          end
          errors = errors + 1;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int n;

    // Directed part. Time starts at zero after reset.
    // A tick with nothing loaded is idle but still advances time.
    queue_ticks(1);
    // Lowest and highest slot, plus a slot with the largest arrival and
    // burst, which stays out of reach until it is disarmed below.
    queue_beat(srtf_pkg::ACT_LOAD, 0, 0, 3);
    queue_beat(srtf_pkg::ACT_LOAD, srtf_pkg::SLOTS - 1, 0, 1);
    queue_beat(srtf_pkg::ACT_LOAD, 5, TIME_TOP, TIME_TOP);
    // The short slot finishes first, then slot 0 runs without finishing.
    queue_ticks(2);
    // Reload slot 0 while it still has work, and add two equal bursts so
    // the lowest slot wins the tie.
    queue_beat(srtf_pkg::ACT_LOAD, 0, 2, 2);
    queue_beat(srtf_pkg::ACT_LOAD, 7, 3, 2);
    queue_beat(srtf_pkg::ACT_LOAD, 3, 3, 2);
    // A one-tick job that arrives later and preempts the others.
    queue_beat(srtf_pkg::ACT_LOAD, 9, 5, 1);
    queue_ticks(4);
    // A burst of zero disarms the far-future slot.
    queue_beat(srtf_pkg::ACT_LOAD, 5, 0, 0);
    // Drain what is left; the last tick finds nothing to run.
    queue_ticks(4);

    // Random part: a mix of ticks and loads.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if ($urandom_range(0, 99) < 55) queue_ticks(1);
      else queue_random_load();
    end

    // Hold reset, then release it with a nonblocking write so the driver,
    // which also wakes on this edge, sees reset still asserted.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tick_results_q.size() != 0) errors = errors + 1;

    if (errors == 0) begin
      $display("srtf_tick_scheduler_top_test passed");
    end else begin
      $display("srtf_tick_scheduler_top_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
